[rtl/row_rle_sprite_decoder_assert.svh]
// assertion macros for the checker file
`ifndef ROW_RLE_SPRITE_DECODER_ASSERT_SVH
`define ROW_RLE_SPRITE_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RRSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RRSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrsd_pkg.sv]
// shared types and constants of the row run-length sprite decoder
package rrsd_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MAX_ROWS_DEFAULT  = 4096;

  localparam int PIX_W   = 8;
  localparam int RUN_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL = 1'b1;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 13'd64;
  localparam logic [CFG_W-1:0] ROW_TOTAL_RESET = 13'd64;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [RUN_W-1:0] run_length;
    logic             end_of_row;
    logic             end_of_frame;
    logic             format_error;
    logic             last_of_item;
  } result_t;

  // results of one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[rtl/row_rle_sprite_decoder.sv]
// latency: runs of a byte enter the result buffer the cycle after its transfer
// throughput: one byte per cycle while each byte yields at most one run and the
//   master side takes every run; a byte that yields two runs takes two output transfers
// a byte is taken while the four-entry result buffer has two free entries
// reset clears row state and the buffer and sets row_width and row_total to 64
module row_rle_sprite_decoder #(
  parameter int MAX_WIDTH = rrsd_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_ROWS  = rrsd_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrsd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // data_byte
  input  logic [0:0]                     s_tuser,   // frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_value[7:0], run_length[20:8], end_of_row[21], last_of_item[22], zero[23]
  output logic [23:0]                    m_tdata,
  output logic [0:0]                     m_tuser,   // format_error
  output logic                           m_tlast    // end_of_frame
);

  rrsd_pkg::push_t   push;
  rrsd_pkg::result_t res;
  logic              room;

  assign cfg_ready = 1'b1;
  assign s_tready = room;

  rrsd_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (s_tvalid && s_tready),
    .data_byte  (s_tdata),
    .frame_start(s_tuser[0]),
    .push       (push)
  );

  rrsd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (res)
  );

  assign m_tdata = {1'b0, res.last_of_item, res.end_of_row, res.run_length, res.pixel_value};
  assign m_tuser = res.format_error;
  assign m_tlast = res.end_of_frame;

endmodule

[rtl/rrsd_core.sv]
// row decoder state, configuration registers and per-byte run generation
module rrsd_core #(
  parameter int MAX_WIDTH = rrsd_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_ROWS  = rrsd_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rrsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrsd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            take,
  input  logic [7:0]                      data_byte,
  input  logic                            frame_start,
  output rrsd_pkg::push_t                 push
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = (CW > 8) ? CW : 8;
  localparam int EW    = (CW > rrsd_pkg::CFG_W) ? CW : rrsd_pkg::CFG_W;
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int RE    = RB + 1;
  localparam int ER    = (RE > rrsd_pkg::CFG_W) ? RE : rrsd_pkg::CFG_W;
  localparam int RUN_W = rrsd_pkg::RUN_W;

  typedef enum logic [4:0] {
    PH_CNT_LO = 5'b00001,
    PH_CNT_HI = 5'b00010,
    PH_CMD    = 5'b00100,
    PH_REP    = 5'b01000,
    PH_LIT    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              valid;
    rrsd_pkg::result_t rec;
    logic [CW-1:0]     col;
  } emit_t;

  logic [rrsd_pkg::CFG_W-1:0] row_width;
  logic [rrsd_pkg::CFG_W-1:0] row_total;

  phase_t        phase, phase_next;
  logic [15:0]   bytes_left, bytes_left_next;
  logic [7:0]    count_low, count_low_next;
  logic [CW-1:0] column, column_next;
  logic [RB-1:0] row_index, row_index_next;
  logic [6:0]    pending_length, pending_length_next;

  phase_t        ph;
  logic [15:0]   bl, bl_dec;
  logic [7:0]    cl;
  logic [CW-1:0] col, col_mid;
  logic [RB-1:0] ri;
  logic [6:0]    pl, pl_dec;
  logic [RE-1:0] ri_inc;

  logic [CW-1:0] eff_width;
  logic [RE-1:0] eff_rows;
  logic          last_row;

  logic          e1_do, fin, trunc;
  logic [7:0]    e1_val;
  logic [LW-1:0] e1_len;
  emit_t         e1, e2;

  function automatic logic [CW-1:0] remaining(input logic [CW-1:0] c,
                                              input logic [CW-1:0] w);
    remaining = (c < w) ? (w - c) : '0;
  endfunction

  // one run against the row end: clip, advance column, flag row and frame end
  function automatic emit_t emit(input logic [CW-1:0] c, input logic [CW-1:0] w,
                                 input logic lrow, input logic [7:0] val,
                                 input logic [LW-1:0] len, input logic err);
    emit_t         e;
    logic [LW-1:0] rem;
    logic [LW-1:0] l;
    logic          clip;
    logic          eor;
    rem  = LW'(remaining(c, w));
    clip = len > rem;
    l    = clip ? rem : len;
    e.col = c + CW'(l);
    eor  = (l != '0) && (e.col >= w);
    e.valid = (l != '0) || clip || err;
    e.rec.pixel_value  = val;
    e.rec.run_length   = RUN_W'(l);
    e.rec.end_of_row   = eor;
    e.rec.end_of_frame = eor && lrow;
    e.rec.format_error = clip || err;
    e.rec.last_of_item = 1'b0;
    emit = e;
  endfunction

  always_comb begin
    if (row_width == '0) begin
      eff_width = CW'(1);
    end else if (EW'(row_width) > EW'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = CW'(row_width);
    end
    if (row_total == '0) begin
      eff_rows = RE'(1);
    end else if (ER'(row_total) > ER'(MAX_ROWS)) begin
      eff_rows = RE'(MAX_ROWS);
    end else begin
      eff_rows = RE'(row_total);
    end
  end

  always_comb begin
    // frame start restarts the row state before the byte is taken
    ph = frame_start ? PH_CNT_LO : phase;
    bl = frame_start ? '0 : bytes_left;
    cl = frame_start ? '0 : count_low;
    col = frame_start ? '0 : column;
    ri = frame_start ? '0 : row_index;
    pl = frame_start ? '0 : pending_length;

    bl_dec = bl - 16'd1;
    pl_dec = (pl != '0) ? (pl - 7'd1) : '0;
    ri_inc = RE'(ri) + RE'(1);
    last_row = ri_inc >= eff_rows;

    phase_next = ph;
    bytes_left_next = bl;
    count_low_next = cl;
    pending_length_next = pl;
    e1_do = 1'b0;
    e1_val = '0;
    e1_len = '0;
    fin = 1'b0;
    trunc = 1'b0;

    unique case (ph)
      PH_CNT_LO: begin
        count_low_next = data_byte;
        phase_next = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        bytes_left_next = {data_byte, cl};
        if ({data_byte, cl} == 16'd0) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        bytes_left_next = bl_dec;
        if (data_byte[0]) begin
          e1_do = 1'b1;
          e1_len = LW'(data_byte[7:1]);
          fin = (bl_dec == 16'd0);
        end else begin
          pending_length_next = 7'(data_byte[7:2]) + 7'd1;
          if (bl_dec == 16'd0) begin
            fin = 1'b1;
            trunc = 1'b1;
          end else begin
            phase_next = data_byte[1] ? PH_REP : PH_LIT;
          end
        end
      end
      PH_REP: begin
        bytes_left_next = bl_dec;
        e1_do = 1'b1;
        e1_val = data_byte;
        e1_len = LW'(pl);
        pending_length_next = '0;
        if (bl_dec == 16'd0) begin
          fin = 1'b1;
        end else begin
          phase_next = PH_CMD;
        end
      end
      PH_LIT: begin
        bytes_left_next = bl_dec;
        e1_do = 1'b1;
        e1_val = data_byte;
        e1_len = LW'(1);
        pending_length_next = pl_dec;
        if (bl_dec == 16'd0) begin
          fin = 1'b1;
          trunc = (pl_dec != '0);
        end else if (pl_dec == '0) begin
          phase_next = PH_CMD;
        end
      end
      default: begin
        phase_next = PH_CNT_LO;
      end
    endcase

    e1 = emit(col, eff_width, last_row, e1_val, e1_len, 1'b0);
    e1.valid = e1.valid && e1_do;
    col_mid = e1_do ? e1.col : col;

    // row padding run takes whatever is left of the row
    e2 = emit(col_mid, eff_width, last_row, 8'd0,
              LW'(remaining(col_mid, eff_width)), trunc);
    e2.valid = e2.valid && fin;

    if (fin) begin
      row_index_next = last_row ? '0 : RB'(ri_inc);
      column_next = '0;
      pending_length_next = '0;
      phase_next = PH_CNT_LO;
    end else begin
      row_index_next = ri;
      column_next = col_mid;
    end

    push.first = e1.valid ? e1.rec : e2.rec;
    push.second = e2.rec;
    push.second.last_of_item = 1'b1;
    push.first.last_of_item = !(e1.valid && e2.valid);
    if (!take) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, e1.valid} + {1'b0, e2.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= rrsd_pkg::ROW_WIDTH_RESET;
      row_total <= rrsd_pkg::ROW_TOTAL_RESET;
      phase <= PH_CNT_LO;
      bytes_left <= '0;
      count_low <= '0;
      column <= '0;
      row_index <= '0;
      pending_length <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          rrsd_pkg::REG_ROW_WIDTH: row_width <= cfg_data;
          rrsd_pkg::REG_ROW_TOTAL: row_total <= cfg_data;
        endcase
      end
      if (take) begin
        phase <= phase_next;
        bytes_left <= bytes_left_next;
        count_low <= count_low_next;
        column <= column_next;
        row_index <= row_index_next;
        pending_length <= pending_length_next;
      end
    end
  end

endmodule

[rtl/rrsd_fifo.sv]
// result buffer: takes up to two results per cycle, hands out one per transfer
module rrsd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  rrsd_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output rrsd_pkg::result_t out_data
);

  localparam int DEPTH = rrsd_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rrsd_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign pop = out_valid && out_ready;
  // accept a byte only while two results still fit
  assign room = (count <= CNT_W'(DEPTH - 2));
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

[rtl/rrsd_checker.sv]
// port-level checker for the sprite decoder and its bind
`include "row_rle_sprite_decoder_assert.svh"

module rrsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  `RRSD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // frame end only on a row end
  `RRSD_ASSERT_IMPLY(a_eof_eor, clk, rst, m_tvalid && m_tlast, m_tdata[21], "frame end without row end")

  // empty run only as an error marker
  `RRSD_ASSERT_IMPLY(a_empty_err, clk, rst, m_tvalid && (m_tdata[20:8] == 13'd0), m_tuser[0], "empty run without format error")

  // a row end comes from a run that covers pixels
  `RRSD_ASSERT_IMPLY(a_eor_len, clk, rst, m_tvalid && m_tdata[21], m_tdata[20:8] != 13'd0, "row end on empty run")

endmodule

bind row_rle_sprite_decoder rrsd_checker u_rrsd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

[tb/tb.sv]
// self-checking testbench for the row run-length sprite decoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 22;
  localparam int ITEM_GOAL    = 1750;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 100;
  localparam int STALL_LIMIT  = 2000;

  localparam int CFG_IDX_W = rrsd_pkg::CFG_IDX_W;
  localparam int CFG_W     = rrsd_pkg::CFG_W;
  localparam int RUN_W     = rrsd_pkg::RUN_W;

  // command byte encoding
  localparam logic       ZERO_RUN_FLAG = 1'b1;
  localparam logic [1:0] KIND_REPEAT   = 2'b10;
  localparam logic [1:0] KIND_LITERAL  = 2'b00;

  typedef enum logic [4:0] {
    PH_COUNT_LO    = 5'b00001,
    PH_COUNT_HI    = 5'b00010,
    PH_COMMAND     = 5'b00100,
    PH_REPEAT_BYTE = 5'b01000,
    PH_LITERAL     = 5'b10000
  } dec_phase_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = rrsd_pkg::REG_ROW_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic [0:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              m_tlast;

  row_rle_sprite_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted from the accepted bytes
  logic [CFG_W-1:0] shape_width;
  logic [CFG_W-1:0] shape_rows;
  dec_phase_t       dec_phase;
  logic [15:0]      bytes_left;
  logic [7:0]       count_low;
  int unsigned      column;
  int unsigned      row_index;
  int unsigned      pending_len;

  rrsd_pkg::result_t new_runs[$];
  rrsd_pkg::result_t runs_due[$];

  int mismatches   = 0;
  int bytes_sent   = 0;
  int stall_cycles = 0;
  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  logic hold_rx    = 1'b0;

  function automatic int unsigned width_eff();
    if (shape_width == 0) return 1;
    if (shape_width > rrsd_pkg::MAX_WIDTH_DEFAULT) return rrsd_pkg::MAX_WIDTH_DEFAULT;
    return shape_width;
  endfunction

  function automatic int unsigned rows_eff();
    if (shape_rows == 0) return 1;
    if (shape_rows > rrsd_pkg::MAX_ROWS_DEFAULT) return rrsd_pkg::MAX_ROWS_DEFAULT;
    return shape_rows;
  endfunction

  function automatic void clear_rows();
    dec_phase   = PH_COUNT_LO;
    bytes_left  = '0;
    count_low   = '0;
    column      = 0;
    row_index   = 0;
    pending_len = 0;
  endfunction

  function automatic void emit_run(input logic [7:0] pix, input int unsigned len,
                                   input logic err);
    int unsigned w = width_eff();
    int unsigned room = (column < w) ? w - column : 0;
    rrsd_pkg::result_t r;
    if (len > room) begin
      len = room;
      err = 1'b1;
    end
    if (len == 0 && !err) return;
    column += len;
    r.pixel_value  = pix;
    r.run_length   = RUN_W'(len);
    r.end_of_row   = (len > 0) && (column >= w);
    r.end_of_frame = r.end_of_row && (row_index + 1 >= rows_eff());
    r.format_error = err;
    r.last_of_item = 1'b0;
    new_runs.push_back(r);
  endfunction

  // pad the row with transparent pixels and move to the next row
  function automatic void close_row(input logic truncated);
    int unsigned w = width_eff();
    emit_run(8'h00, (column < w) ? w - column : 0, truncated);
    row_index++;
    if (row_index >= rows_eff()) row_index = 0;
    column      = 0;
    pending_len = 0;
    dec_phase   = PH_COUNT_LO;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic frame_head);
    new_runs.delete();
    if (frame_head) clear_rows();
    unique case (dec_phase)
      PH_COUNT_LO: begin
        count_low = b;
        dec_phase = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        bytes_left = {b, count_low};
        if (bytes_left == 0) close_row(1'b0);
        else dec_phase = PH_COMMAND;
      end
      PH_COMMAND: begin
        bytes_left = bytes_left - 16'd1;
        if (b[0] == ZERO_RUN_FLAG) begin
          emit_run(8'h00, b >> 1, 1'b0);
          if (bytes_left == 0) close_row(1'b0);
        end else begin
          pending_len = (b >> 2) + 1;
          if (bytes_left == 0) close_row(1'b1);
          else dec_phase = (b[1:0] == KIND_REPEAT) ? PH_REPEAT_BYTE : PH_LITERAL;
        end
      end
      PH_REPEAT_BYTE: begin
        bytes_left = bytes_left - 16'd1;
        emit_run(b, pending_len, 1'b0);
        pending_len = 0;
        if (bytes_left == 0) close_row(1'b0);
        else dec_phase = PH_COMMAND;
      end
      PH_LITERAL: begin
        bytes_left = bytes_left - 16'd1;
        emit_run(b, 1, 1'b0);
        if (pending_len > 0) pending_len--;
        if (bytes_left == 0) close_row(pending_len != 0);
        else if (pending_len == 0) dec_phase = PH_COMMAND;
      end
      default: dec_phase = PH_COUNT_LO;
    endcase
    if (new_runs.size() > 0) new_runs[new_runs.size() - 1].last_of_item = 1'b1;
    foreach (new_runs[i]) runs_due.push_back(new_runs[i]);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic check_run();
    rrsd_pkg::result_t want;
    if (runs_due.size() == 0) begin
      report_mismatch("run with nothing due", 0, 1);
      return;
    end
    want = runs_due.pop_front();
    if (m_tdata[7:0] != want.pixel_value)
      report_mismatch("pixel_value", want.pixel_value, m_tdata[7:0]);
    if (m_tdata[20:8] != want.run_length)
      report_mismatch("run_length", want.run_length, m_tdata[20:8]);
    if (m_tdata[21] != want.end_of_row)
      report_mismatch("end_of_row", want.end_of_row, m_tdata[21]);
    if (m_tlast != want.end_of_frame)
      report_mismatch("end_of_frame", want.end_of_frame, m_tlast);
    if (m_tuser[0] != want.format_error)
      report_mismatch("format_error", want.format_error, m_tuser[0]);
    if (m_tdata[22] != want.last_of_item)
      report_mismatch("last_of_item", want.last_of_item, m_tdata[22]);
  endtask

  // one process sees every transfer: config, input byte and output run
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rrsd_pkg::REG_ROW_WIDTH) shape_width = cfg_data;
        else shape_rows = cfg_data;
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) check_run();
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk)
    m_tready <= !hold_rx && ($urandom_range(99) >= out_idle_pct);

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] zero_run_cmd(input int len);
    return {7'(len), ZERO_RUN_FLAG};
  endfunction

  function automatic logic [7:0] repeat_cmd(input int pixels);
    return {6'(pixels - 1), KIND_REPEAT};
  endfunction

  function automatic logic [7:0] literal_cmd(input int pixels);
    return {6'(pixels - 1), KIND_LITERAL};
  endfunction

  // mostly short runs, now and then up to the full field
  function automatic int pick_len(input int most);
    if ($urandom_range(3) != 0) return $urandom_range(1, (most < 8) ? most : 8);
    return $urandom_range(1, most);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic frame_head);
    while ($urandom_range(99) < in_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tuser[0] <= frame_head;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // stop input and let every due run and any late run come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (runs_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input int w, input int rows);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= rrsd_pkg::REG_ROW_WIDTH;
    cfg_data  <= CFG_W'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rrsd_pkg::REG_ROW_TOTAL;
    cfg_data  <= CFG_W'(rows);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_row(input logic frame_head, input bit broken);
    logic [7:0] body[$];
    logic [15:0] row_count;
    int n_cmds;
    int n;
    n_cmds = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n_cmds) begin
      case ($urandom_range(2))
        0: body.push_back(zero_run_cmd(pick_len(128) - 1));
        1: begin
          body.push_back(repeat_cmd(pick_len(64)));
          body.push_back(8'($urandom));
        end
        default: begin
          n = pick_len(64);
          body.push_back(literal_cmd(n));
          repeat (n) body.push_back(8'($urandom));
        end
      endcase
    end
    row_count = 16'(body.size());
    // a wrong count cuts a command short or swallows bytes of the next row
    if (broken) row_count = 16'($urandom_range(0, body.size() + 3));
    send_byte(row_count[7:0], frame_head);
    send_byte(row_count[15:8], 1'b0);
    foreach (body[i]) send_byte(body[i], 1'b0);
  endtask

  task automatic send_frame();
    int n_rows;
    n_rows = (rows_eff() <= 8) ? rows_eff() + $urandom_range(0, 1) : $urandom_range(1, 6);
    for (int r = 0; r < n_rows; r++) begin
      if ($urandom_range(24) == 0) send_byte(8'($urandom), $urandom_range(9) == 0);
      send_row(r == 0, $urandom_range(99) < 12);
    end
  endtask

  task automatic run_frames(input int goal);
    while (bytes_sent < goal) send_frame();
  endtask

  task automatic test_directed();
    logic [7:0] stream[$];
    stream = {
      // empty row: one padding run on the high count byte
      8'd0, 8'd0,
      8'd10, 8'd0,
      zero_run_cmd(0),
      repeat_cmd(2), 8'hFF,
      literal_cmd(2), 8'h00, 8'h80,
      zero_run_cmd(127),
      zero_run_cmd(1),
      repeat_cmd(1), 8'h11,
      // count runs out inside a literal
      8'd3, 8'd0,
      literal_cmd(4), 8'h55, 8'h66,
      // count runs out on the command itself
      8'd1, 8'd0,
      repeat_cmd(64)
    };
    foreach (stream[i]) send_byte(stream[i], i == 0);
  endtask

  task automatic test_width_change();
    set_shape(16, 4);
    send_byte(8'd3, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(zero_run_cmd(15), 1'b0);
    // column 15 is past the new width, so the row counts as full
    set_shape(8, 4);
    send_byte(zero_run_cmd(2), 1'b0);
    send_byte(zero_run_cmd(1), 1'b0);
  endtask

  task automatic test_config_sweep();
    int widths[8] = '{1, 4096, 0, 2, 16, 8191, 37, 64};
    int totals[8] = '{1, 4096, 0, 2, 4, 1, 8191, 64};
    foreach (widths[i]) begin
      set_shape(widths[i], totals[i]);
      run_frames(bytes_sent + 140);
    end
  endtask

  task automatic test_backpressure();
    set_shape(8, 4);
    in_idle_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
      begin
        run_frames(bytes_sent + 100);
        s_tvalid <= 1'b0;
      end
    join
    in_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_long();
    set_shape($urandom_range(1, 48), $urandom_range(1, 6));
    in_idle_pct = 0;
    out_idle_pct <= 0;
    run_frames(bytes_sent + 200);
    in_idle_pct = IDLE_PCT;
    out_idle_pct <= IDLE_PCT;
    run_frames(bytes_sent + (ITEM_GOAL - bytes_sent) / 2);
    set_shape($urandom_range(1, 96), $urandom_range(1, 8));
    run_frames(ITEM_GOAL);
  endtask

  initial begin
    shape_width = rrsd_pkg::ROW_WIDTH_RESET;
    shape_rows  = rrsd_pkg::ROW_TOTAL_RESET;
    clear_rows();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_width_change();
    test_config_sweep();
    test_backpressure();
    test_random_long();
    wait_idle();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
